// ===== rtl/swa_pkg.sv =====
`timescale 1ns / 1ps

package swa_pkg;

  // Window store depth and sample width
  localparam int WINDOW_MAX  = 16;
  localparam int SAMPLE_BITS = 16;
  localparam int AVG_BITS    = 16;

  // Window length register
  localparam int CFG_BITS   = 5;
  localparam int CFG_RESET  = 16;
  localparam int PADDR_BITS = 3;
  localparam int PDATA_BITS = 32;

  // Derived widths
  localparam int IDX_BITS = $clog2(WINDOW_MAX);
  localparam int LEN_BITS = $clog2(WINDOW_MAX + 1);
  localparam int SUM_BITS = SAMPLE_BITS + IDX_BITS + 1;
  localparam int MAG_BITS = SAMPLE_BITS + IDX_BITS;
  localparam int CNT_BITS = ($clog2(MAG_BITS) > IDX_BITS) ? $clog2(MAG_BITS) : IDX_BITS;

  // Register indexes
  localparam int REG_WINDOW_LENGTH = 0;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [AVG_BITS-1:0]    avg_t;
  typedef logic [LEN_BITS-1:0]           len_t;

  // Controller commands to the datapath
  typedef struct packed {
    logic start;
    logic sum_step;
    logic prep;
    logic div_step;
    logic load_out;
  } swa_cmd_t;

  // Datapath status to the controller
  typedef struct packed {
    logic out_free;
  } swa_sts_t;

endpackage

// ===== rtl/swa_sample_if.sv =====
`timescale 1ns / 1ps

interface swa_sample_if;
  import swa_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);

endinterface

// ===== rtl/swa_avg_if.sv =====
`timescale 1ns / 1ps

interface swa_avg_if;
  import swa_pkg::*;

  logic valid;
  logic ready;
  avg_t average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);

endinterface

// ===== rtl/swa_ctrl.sv =====
`timescale 1ns / 1ps

module swa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  swa_pkg::len_t     len,
  input  swa_pkg::swa_sts_t sts,
  output swa_pkg::swa_cmd_t cmd
);
  import swa_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SUM  = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [CNT_BITS-1:0] cnt, cnt_next;
  logic [CNT_BITS-1:0] sum_last;

  assign sum_last = CNT_BITS'(len - LEN_BITS'(1));

  // Sequence one beat: accept, sum window, prepare, divide, hand off
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          cnt_next   = '0;
          state_next = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (cnt == sum_last) begin
          state_next = ST_PREP;
        end else begin
          cnt_next = cnt + CNT_BITS'(1);
        end
      end
      ST_PREP: begin
        cmd.prep   = 1'b1;
        cnt_next   = '0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == CNT_BITS'(MAG_BITS - 1)) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + CNT_BITS'(1);
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  // An accepted beat always starts the window sum
  a_accept_sum: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_SUM))
    else $error("accepted beat did not start summing");

  // Division always follows the prepare step
  a_prep_div: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PREP) |=> (state == ST_DIV && cnt == '0))
    else $error("prepare step not followed by division");

  // Never overwrite a result that is still waiting
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded into a full output register");

endmodule

// ===== rtl/swa_dp.sv =====
`timescale 1ns / 1ps

module swa_dp (
  input  logic              clk,
  input  logic              rst,
  input  swa_pkg::swa_cmd_t cmd,
  output swa_pkg::swa_sts_t sts,
  input  swa_pkg::len_t     len,
  input  swa_pkg::sample_t  in_sample,
  output logic              out_valid,
  input  logic              out_ready,
  output swa_pkg::avg_t     out_average
);
  import swa_pkg::*;

  sample_t               win [WINDOW_MAX];
  logic [WINDOW_MAX-1:0] win_valid;
  logic [IDX_BITS-1:0]   pos;
  logic [IDX_BITS-1:0]   rd;
  logic signed [SUM_BITS-1:0] acc;
  logic [LEN_BITS-1:0]   rem;
  logic [MAG_BITS-1:0]   quo;
  logic                  neg;
  avg_t                  avg_data;
  logic                  avg_valid;

  sample_t               rd_data;
  logic [SUM_BITS-1:0]   acc_neg;
  logic [SUM_BITS-1:0]   acc_up;
  logic [LEN_BITS:0]     trial;
  logic                  fits;
  logic [MAG_BITS-1:0]   quo_neg;

  // Slots not written since reset read as zero
  assign rd_data = win_valid[rd] ? win[rd] : '0;

  assign acc_neg = '0 - acc;
  assign acc_up  = acc + {{(SUM_BITS-LEN_BITS){1'b0}}, len} - SUM_BITS'(1);
  assign trial   = {rem, quo[MAG_BITS-1]};
  assign fits    = (trial >= {1'b0, len});
  assign quo_neg = '0 - quo;

  assign sts.out_free = !avg_valid || out_ready;
  assign out_valid    = avg_valid;
  assign out_average  = avg_data;

  // Store the new sample and advance the write slot
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      win[pos] <= in_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid <= '0;
      pos       <= '0;
    end else if (cmd.start) begin
      win_valid[pos] <= 1'b1;
      pos <= (pos == IDX_BITS'(WINDOW_MAX - 1)) ? '0 : pos + IDX_BITS'(1);
    end
  end

  // Accumulate newest samples, then divide by the length with ceiling rounding
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rd  <= pos;
      acc <= '0;
    end else if (cmd.sum_step) begin
      acc <= acc + {{(SUM_BITS-SAMPLE_BITS){rd_data[SAMPLE_BITS-1]}}, rd_data};
      rd  <= (rd == '0) ? IDX_BITS'(WINDOW_MAX - 1) : rd - IDX_BITS'(1);
    end
    if (cmd.prep) begin
      neg <= acc[SUM_BITS-1];
      rem <= '0;
      quo <= acc[SUM_BITS-1] ? acc_neg[MAG_BITS-1:0] : acc_up[MAG_BITS-1:0];
    end else if (cmd.div_step) begin
      rem <= fits ? LEN_BITS'(trial - {1'b0, len}) : trial[LEN_BITS-1:0];
      quo <= {quo[MAG_BITS-2:0], fits};
    end
  end

  // Hold the result until the sink takes the beat
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      avg_data <= neg ? quo_neg[AVG_BITS-1:0] : quo[AVG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_valid <= 1'b0;
    end else if (cmd.load_out) begin
      avg_valid <= 1'b1;
    end else if (out_ready) begin
      avg_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/sliding_window_average.sv =====
`timescale 1ns / 1ps

// Channel     Dir  Handshake                   Payload
// sample_ch   in   valid/ready                 sample  (16 bit signed)
// average_ch  out  valid/ready                 average (16 bit signed)
// APB         in   psel/penable/pwrite/pready  window_length at 0x0
//
// A beat runs from acceptance through the window sum, one step per summed
// window slot, a prepare step, a 20-step restoring divider and a hand-off
// step that loads the result into the output register; one beat is in
// flight at a time. Reset (synchronous) clears the window store through
// per-slot valid bits. A finished result waits in the output register; a
// new sample is taken while it waits, and the next result stalls until the
// register is free.

module sliding_window_average (
  input  logic                           clk,
  input  logic                           rst,
  swa_sample_if.sink                     sample_ch,
  swa_avg_if.source                      average_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [swa_pkg::PADDR_BITS-1:0] paddr,
  input  logic [swa_pkg::PDATA_BITS-1:0] pwdata,
  output logic [swa_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready
);
  import swa_pkg::*;

  logic [CFG_BITS-1:0] window_length;
  len_t                len;
  logic                reg_hit;
  swa_cmd_t            cmd;
  swa_sts_t            sts;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_BITS-1:2] == (PADDR_BITS-2)'(REG_WINDOW_LENGTH));

  // Write the length register on the access cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= CFG_BITS'(CFG_RESET);
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      window_length <= pwdata[CFG_BITS-1:0];
    end
  end

  assign prdata = reg_hit ? {{(PDATA_BITS-CFG_BITS){1'b0}}, window_length} : '0;

  // Clamp the length into one to the store depth
  always_comb begin
    if (window_length == '0) begin
      len = LEN_BITS'(1);
    end else if (32'(window_length) > 32'(WINDOW_MAX)) begin
      len = LEN_BITS'(WINDOW_MAX);
    end else begin
      len = LEN_BITS'(window_length);
    end
  end

  swa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (sample_ch.valid),
    .in_ready (sample_ch.ready),
    .len      (len),
    .sts      (sts),
    .cmd      (cmd)
  );

  swa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .len         (len),
    .in_sample   (sample_ch.sample),
    .out_valid   (average_ch.valid),
    .out_ready   (average_ch.ready),
    .out_average (average_ch.average)
  );

endmodule

// ===== tb/sliding_window_average_tb.sv =====
`timescale 1ns / 1ps

module sliding_window_average_tb;
  import swa_pkg::*;

  localparam int       REG_UNUSED    = 1;
  localparam int       SETTLE_CYCLES = 64;
  localparam int       LONG_STALL    = 300;
  localparam int       SEG_ITEMS     = 139;
  localparam int       SEG_COUNT     = 9;
  localparam int       CYCLE_LIMIT   = 500000;
  localparam sample_t  SMAX          = 16'sh7FFF;
  localparam sample_t  SMIN          = 16'sh8000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Drive-side copies of the channel handshakes, known from time zero
  logic    in_valid  = 1'b0;
  sample_t in_sample = '0;
  logic    out_ready = 1'b0;

  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [PADDR_BITS-1:0] paddr   = '0;
  logic [PDATA_BITS-1:0] pwdata  = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;

  swa_sample_if sample_ch ();
  swa_avg_if    average_ch ();

  assign sample_ch.valid  = in_valid;
  assign sample_ch.sample = in_sample;
  assign average_ch.ready = out_ready;

  sliding_window_average u_dut (
    .clk        (clk),
    .rst        (rst),
    .sample_ch  (sample_ch),
    .average_ch (average_ch),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow of the filter: window store, write slot, length register
  sample_t             hist [WINDOW_MAX] = '{default: '0};
  logic [IDX_BITS-1:0] hist_wr = '0;
  logic [CFG_BITS-1:0] len_reg = CFG_BITS'(CFG_RESET);

  sample_t sample_backlog [$];
  avg_t    avg_due [$];

  int src_idle_pct = 0;
  int snk_idle_pct = 0;
  int stall_req    = 0;
  int stall_seen   = 0;
  int stall_left   = 0;
  int accepted_cnt = 0;
  int checked_cnt  = 0;
  int mismatch_cnt = 0;
  int cycle_cnt    = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Store the new sample, sum the newest window, divide rounding up
  function automatic avg_t next_average(sample_t s);
    int n;
    int acc;
    int slot;
    int k;
    if (len_reg == 0) begin
      n = 1;
    end else if (len_reg > WINDOW_MAX) begin
      n = WINDOW_MAX;
    end else begin
      n = int'(len_reg);
    end
    hist[hist_wr] = s;
    acc = 0;
    slot = int'(hist_wr);
    for (k = 0; k < n; k++) begin
      acc += hist[slot];
      slot = (slot == 0) ? WINDOW_MAX - 1 : slot - 1;
    end
    hist_wr = hist_wr + 1'b1;
    if (acc >= 0) begin
      return avg_t'((acc + n - 1) / n);
    end
    return avg_t'(-((-acc) / n));
  endfunction

  // Sample driver: hold a beat until taken, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && sample_ch.ready) begin
        avg_due.push_back(next_average(in_sample));
        void'(sample_backlog.pop_front());
        accepted_cnt++;
      end
      if (!in_valid || sample_ch.ready) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          in_valid  <= 1'b1;
          in_sample <= sample_backlog[0];
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long output hold-off, counted down on request
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_seen != stall_req) begin
      stall_seen <= stall_req;
      stall_left <= LONG_STALL;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Average monitor: compare each beat with the oldest expected average
  always @(posedge clk) begin
    avg_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (average_ch.valid && out_ready) begin
        if (avg_due.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) begin
            $display("unexpected average beat %0d", average_ch.average);
          end
        end else begin
          want = avg_due.pop_front();
          checked_cnt++;
          if (average_ch.average !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("average mismatch: expected %0d, got %0d", want, average_ch.average);
            end
          end
        end
      end
      out_ready <= (stall_left == 0) && ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still due", cycle_cnt, avg_due.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Register write: setup cycle, then access cycle until pready
  task automatic apb_write(input int idx, input logic [CFG_BITS-1:0] field);
    logic [PDATA_BITS-1:0] word;
    logic [PADDR_BITS-1:0] addr;
    word = $urandom;
    word[CFG_BITS-1:0] = field;
    addr = PADDR_BITS'(idx * 4);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) begin
      len_reg = field;
    end
  endtask

  // Wait until every queued sample is taken and every average has come back
  task automatic wait_idle();
    while (sample_backlog.size() != 0 || avg_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Random samples, with runs of one value to build up full-scale sums
  task automatic queue_random(input int count);
    int      run_left;
    sample_t run_val;
    int      i;
    run_left = 0;
    run_val  = '0;
    for (i = 0; i < count; i++) begin
      if (run_left == 0 && $urandom_range(7) == 0) begin
        run_left = $urandom_range(20, 1);
        case ($urandom_range(3))
          0: run_val = SMAX;
          1: run_val = SMIN;
          2: run_val = -16'sd1;
          default: run_val = sample_t'($urandom);
        endcase
      end
      if (run_left != 0) begin
        sample_backlog.push_back(run_val);
        run_left--;
      end else begin
        sample_backlog.push_back(sample_t'($urandom));
      end
    end
  endtask

  initial begin
    int seg_len [SEG_COUNT];
    int seg;
    seg_len = '{1, 16, 0, 31, 17, 5, 2, 15, 0};
    seg_len[SEG_COUNT-1] = $urandom_range(31, 0);
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset length, store still holding reset zeros
    sample_backlog = '{SMAX, SMAX, SMIN, 16'sd1};
    wait_idle();
    // Zero length passes samples through
    apb_write(REG_WINDOW_LENGTH, 5'd0);
    @(negedge clk);
    sample_backlog = '{SMIN, SMAX, 16'sd0, -16'sd1};
    wait_idle();
    // Oversized length saturates at the store depth
    apb_write(REG_WINDOW_LENGTH, 5'd31);
    @(negedge clk);
    sample_backlog = '{16'sd5, -16'sd5, SMAX, SMIN};
    wait_idle();
    // Short window: positive sums round up, negative sums truncate
    apb_write(REG_WINDOW_LENGTH, 5'd3);
    @(negedge clk);
    sample_backlog = '{16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, 16'sd0, SMIN, SMIN};
    wait_idle();
    // Write to an unused index leaves the length alone
    apb_write(REG_UNUSED, 5'd7);
    @(negedge clk);
    sample_backlog = '{16'sd2, 16'sd2};
    wait_idle();

    for (seg = 0; seg < SEG_COUNT; seg++) begin
      apb_write(REG_WINDOW_LENGTH, seg_len[seg][CFG_BITS-1:0]);
      @(negedge clk);
      if (seg < 3) begin
        src_idle_pct = 26;
        snk_idle_pct = 49;
      end else if (seg < 6) begin
        src_idle_pct = 49;
        snk_idle_pct = 26;
      end else begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (seg == 6) begin
        // Keep offering samples while the output is held off
        queue_random(SEG_ITEMS);
        stall_req++;
      end else if (seg == 7) begin
        // Pause the sender until every average is back
        queue_random(SEG_ITEMS / 2);
        while (sample_backlog.size() != 0 || avg_due.size() != 0) @(negedge clk);
        queue_random(SEG_ITEMS - SEG_ITEMS / 2);
      end else begin
        queue_random(SEG_ITEMS);
      end
      wait_idle();
    end

    $display("covered %0d samples and %0d averages over window lengths 0 to 31,",
             accepted_cnt, checked_cnt);
    $display("with both-side idling, a long output hold-off and a sender pause");
    if (mismatch_cnt == 0 && avg_due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
